@@ sv/bounded_array_list_assert.svh @@
// Assertion macros used by the checker file.
`ifndef BOUNDED_ARRAY_LIST_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, quiet while in reset.
`define BAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, quiet while in reset.
`define BAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bal_pkg.sv @@
`timescale 1ns / 1ps

package bal_pkg;

    localparam int DEPTH      = 256;
    localparam int WORD_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 11;
    localparam int CAP_LIMIT  = 1024;
    localparam int CAP_RESET  = 16;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 8;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [STATUS_W-1:0]       status;
        logic [CNT_W-1:0]          length;
        logic [CAP_W-1:0]          capacity;
    } t_out;

    typedef struct packed {
        logic                  we;
        logic [AW-1:0]         waddr;
        logic [WORD_WIDTH-1:0] wdata;
        logic                  re;
        logic [AW-1:0]         raddr;
    } t_mem_req;

endpackage

@@ sv/bal_store.sv @@
`timescale 1ns / 1ps

module bal_store (
    input  logic                           i_clk,
    input  bal_pkg::t_mem_req              i_req,
    output logic [bal_pkg::WORD_WIDTH-1:0] o_rdata
);

    logic [bal_pkg::WORD_WIDTH-1:0] r_mem [bal_pkg::DEPTH];
    logic [bal_pkg::WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bal_seq.sv @@
`timescale 1ns / 1ps

module bal_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  bal_pkg::t_in                   i_data,
    output logic                           o_busy,
    input  logic                           i_cfg_we,
    input  logic [bal_pkg::CAP_W-1:0]      i_cfg_data,
    output bal_pkg::t_mem_req              o_mem,
    input  logic [bal_pkg::WORD_WIDTH-1:0] i_rdata,
    output logic                           o_res_valid,
    output bal_pkg::t_out                  o_res,
    input  logic                           i_res_ready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                 r_state;
    logic [bal_pkg::CNT_W-1:0]  r_count;
    logic [bal_pkg::CAP_W-1:0]  r_cap;
    logic [bal_pkg::AW-1:0]     r_ptr;
    logic                       r_wr_en;
    logic [bal_pkg::AW-1:0]     r_wr_addr;
    bal_pkg::t_out              r_res;

    logic                       w_accept;
    logic                       w_idx_ok;
    logic                       w_full;
    logic                       w_grow;
    logic [bal_pkg::CAP_W:0]    w_dbl;
    logic [bal_pkg::CAP_W-1:0]  w_grown;
    logic [bal_pkg::CAP_W-1:0]  w_cfg_cap;
    logic [bal_pkg::CNT_W-1:0]  w_ptr_inc;
    logic                       w_more;

    assign w_accept  = i_valid && (r_state == S_IDLE);
    assign w_idx_ok  = bal_pkg::CNT_W'(i_data.index) < r_count;
    assign w_full    = r_count == bal_pkg::CNT_W'(bal_pkg::DEPTH);
    assign w_grow    = (bal_pkg::CAP_W'(r_count) << 1) >= r_cap;
    assign w_dbl     = {r_cap, 1'b0};
    assign w_grown   = (w_dbl > (bal_pkg::CAP_W + 1)'(bal_pkg::CAP_LIMIT))
                     ? bal_pkg::CAP_W'(bal_pkg::CAP_LIMIT) : w_dbl[bal_pkg::CAP_W-1:0];
    assign w_cfg_cap = (i_cfg_data == '0) ? bal_pkg::CAP_W'(1)
                     : (i_cfg_data > bal_pkg::CAP_W'(bal_pkg::CAP_LIMIT))
                     ? bal_pkg::CAP_W'(bal_pkg::CAP_LIMIT) : i_cfg_data;
    assign w_ptr_inc = bal_pkg::CNT_W'(r_ptr) + 1'b1;
    assign w_more    = w_ptr_inc < r_count;

    // One write port: the shift write wins, appends only happen from idle.
    always_comb begin
        o_mem = '0;
        if (r_wr_en) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = r_wr_addr;
            o_mem.wdata = i_rdata;
        end else begin
            o_mem.we    = w_accept && (i_data.kind == bal_pkg::KIND_APPEND) && !w_full;
            o_mem.waddr = r_count[bal_pkg::AW-1:0];
            o_mem.wdata = bal_pkg::WORD_WIDTH'(i_data.value);
        end
        if (r_state == S_SHIFT) begin
            o_mem.re    = w_more;
            o_mem.raddr = w_ptr_inc[bal_pkg::AW-1:0];
        end else begin
            o_mem.re    = w_accept && (i_data.kind == bal_pkg::KIND_READ) && w_idx_ok;
            o_mem.raddr = i_data.index[bal_pkg::AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= bal_pkg::CAP_W'(bal_pkg::CAP_RESET);
            r_wr_en <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= w_cfg_cap;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res.read_value <= '0;
                        r_res.status     <= bal_pkg::ST_OK;
                        r_res.length     <= r_count;
                        r_res.capacity   <= r_cap;
                        r_state          <= S_DONE;
                        case (i_data.kind)
                            bal_pkg::KIND_APPEND: begin
                                if (w_full) begin
                                    r_res.status <= bal_pkg::ST_FULL;
                                end else begin
                                    r_count      <= r_count + 1'b1;
                                    r_res.length <= r_count + 1'b1;
                                    if (w_grow) begin
                                        r_cap          <= w_grown;
                                        r_res.capacity <= w_grown;
                                    end
                                end
                            end
                            bal_pkg::KIND_REMOVE: begin
                                if (!w_idx_ok) begin
                                    r_res.status <= bal_pkg::ST_BAD_IDX;
                                end else begin
                                    r_ptr   <= i_data.index[bal_pkg::AW-1:0];
                                    r_state <= S_SHIFT;
                                end
                            end
                            bal_pkg::KIND_READ: begin
                                if (!w_idx_ok) begin
                                    r_res.status <= bal_pkg::ST_BAD_IDX;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_res.read_value <= bal_pkg::VALUE_W'($signed(i_rdata));
                    r_state          <= S_DONE;
                end
                S_SHIFT: begin
                    // Move the next entry down one place per cycle.
                    if (w_more) begin
                        r_wr_en   <= 1'b1;
                        r_wr_addr <= r_ptr;
                        r_ptr     <= w_ptr_inc[bal_pkg::AW-1:0];
                    end else begin
                        r_wr_en      <= 1'b0;
                        r_count      <= r_count - 1'b1;
                        r_res.length <= r_count - 1'b1;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_res       = r_res;

endmodule

@@ sv/bal_obuf.sv @@
`timescale 1ns / 1ps

module bal_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bal_pkg::t_out i_res,
    output logic          o_ready,
    output logic          o_valid,
    output bal_pkg::t_out o_data,
    input  logic          i_stall
);

    logic          r_valid;
    bal_pkg::t_out r_data;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_ready) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the word while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_data <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/bounded_array_list.sv @@
`timescale 1ns / 1ps
// Ordered list of signed words in a 256-entry store, with a logical capacity.
// Input channel: i_valid / i_data, o_stall back. A word is taken at a clock
// edge with i_valid high and o_stall low; o_stall is high while an item is
// being worked on. Output channel: o_valid / o_data, i_stall back; one result
// word per input word, held stable while i_stall is high.
// After accept, append, bad index and unused kinds go straight to the done
// state; a read passes through a read state first, and a remove through a
// shift state that walks the store one entry per cycle through its single
// read and single write port. The block can take the next word in the cycle
// after the previous result enters the output register.
// A result can wait in the output register while the next word is taken.
// i_cfg_we writes the current capacity (0 reads as 1, above 1024 as 1024);
// write only while the block is idle.
// Synchronous reset (i_rst_n low) empties the list, sets capacity to 16 and
// drops any pending result; store contents are not cleared.
module bounded_array_list (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  bal_pkg::t_in              i_data,
    output logic                      o_stall,
    output logic                      o_valid,
    output bal_pkg::t_out             o_data,
    input  logic                      i_stall,
    input  logic                      i_cfg_we,
    input  logic [bal_pkg::CAP_W-1:0] i_cfg_data
);

    bal_pkg::t_mem_req              w_mem;
    logic [bal_pkg::WORD_WIDTH-1:0] w_rdata;
    logic                           w_busy;
    logic                           w_res_valid;
    bal_pkg::t_out                  w_res;
    logic                           w_res_ready;

    bal_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_busy      (w_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_mem       (w_mem),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    bal_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    bal_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_ready (w_res_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    assign o_stall = w_busy;

endmodule

@@ sv/bal_checker.sv @@
`timescale 1ns / 1ps
`include "bounded_array_list_assert.svh"

module bal_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input bal_pkg::t_out o_data,
    input logic          i_stall
);

    `BAL_ASSERT_NEXT(a_out_hold,
        o_valid && i_stall,
        o_valid && $stable(o_data),
        "result word changed while stalled")
    `BAL_ASSERT_NEXT(a_busy_after_accept,
        i_valid && !o_stall,
        o_stall,
        "input taken again without a busy cycle")
    `BAL_ASSERT_NOW(a_full_length,
        o_valid && (o_data.status == bal_pkg::ST_FULL),
        o_data.length == bal_pkg::CNT_W'(bal_pkg::DEPTH),
        "store full reported below full length")
    `BAL_ASSERT_NOW(a_err_no_data,
        o_valid && (o_data.status != bal_pkg::ST_OK),
        o_data.read_value == '0,
        "error result carries read data")

endmodule

bind bounded_array_list bal_checker u_chk (.*);
